// File: src/tccw_pkg.sv
// Package for the text console cell writer: geometry, codes, request and result types.
`default_nettype none

package tccw_pkg;

  // Screen geometry and tab stops
  localparam int unsigned ROWS      = 24;
  localparam int unsigned COLS      = 80;
  localparam int unsigned TAB_WIDTH = 8;

  localparam int unsigned ROW_W     = $clog2(ROWS);
  localparam int unsigned COL_W     = $clog2(COLS);
  localparam int unsigned DEPTH     = ROWS * COLS;
  localparam int unsigned ADDR_W    = $clog2(DEPTH);
  localparam int unsigned TAB_CNT_W = $clog2(TAB_WIDTH + 1);
  localparam int unsigned CELL_W    = 16;
  localparam int unsigned CFG_W     = 4;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
  localparam logic [7:0]        CH_BS      = 8'h08;
  localparam logic [7:0]        CH_TAB     = 8'h09;
  localparam logic [7:0]        CH_LF      = 8'h0A;
  localparam logic [7:0]        CH_CR      = 8'h0D;
  localparam logic [7:0]        CH_SPACE   = 8'h20;

  // Request operations
  typedef enum logic [2:0] {
    OP_PUT     = 3'd0,
    OP_GOTO    = 3'd1,
    OP_CLS     = 3'd2,
    OP_CLR_EOL = 3'd3,
    OP_CLR_EOS = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  // Interpretation of a put
  typedef enum logic [2:0] {
    PK_GLYPH,
    PK_TAB,
    PK_CR,
    PK_LF,
    PK_BS
  } put_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FG     = 2'd0,
    CFG_BG     = 2'd1,
    CFG_RAW    = 2'd2,
    CFG_CURSOR = 2'd3
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_SWEEP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] target_col;
    logic [7:0] target_row;
  } in_req_t;

  typedef logic [6:0]  out_col_t;
  typedef logic [5:0]  out_row_t;
  typedef logic [11:0] out_off_t;

  typedef struct packed {
    out_col_t    cursor_col;
    out_row_t    cursor_row;
    logic [31:0] scroll_total;
    logic [15:0] cell_value;
    out_off_t    cursor_offset;
    logic        cursor_visible;
  } out_res_t;

  // Map a logical row onto the rotating row store
  function automatic logic [ROW_W-1:0] row_phys(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, top};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  // Cell address of a physical row and a column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

// File: src/text_console_cell_writer_unit.sv
// Top level of the text console cell writer: sequencer, cursor state and result register.
`default_nettype none

// Text-mode screen of ROWS x COLS 16-bit cells held in one RAM. Rows rotate
// through the RAM, so a scroll only bumps the top-row pointer and blanks the
// new bottom row. Each request gives one result. A cell read starts its RAM
// read as the request is taken; a tab writes spaces up to the next tab stop.
// Every scroll adds a bottom-row blanking sweep; clears sweep one cell a cycle
// from the cursor (or the home position) to the end of the line or screen.
// After reset a clearing pass over all ROWS*COLS (1920) cells runs before the
// first request is taken; configuration writes are taken throughout. The next
// request may be taken while a result waits.

module text_console_cell_writer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tccw_pkg::in_req_t           in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tccw_pkg::out_res_t          out_res_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [tccw_pkg::CFG_W-1:0]  cfg_data_i
);

  localparam int unsigned RowW   = tccw_pkg::ROW_W;
  localparam int unsigned ColW   = tccw_pkg::COL_W;
  localparam int unsigned AddrW  = tccw_pkg::ADDR_W;
  localparam int unsigned TcW    = tccw_pkg::TAB_CNT_W;
  localparam int unsigned CellW  = tccw_pkg::CELL_W;
  localparam int unsigned OffW   = tccw_pkg::ADDR_W + 1;

  tccw_pkg::state_e     state_q, state_d;
  tccw_pkg::in_req_t    req_q, req_d;
  logic [RowW-1:0]      cur_row_q, cur_row_d;
  logic [ColW-1:0]      cur_col_q, cur_col_d;
  logic [RowW-1:0]      top_q, top_d;
  logic [31:0]          scroll_q, scroll_d;
  logic [TcW-1:0]       tab_cnt_q, tab_cnt_d;
  logic [RowW-1:0]      sw_row_q, sw_row_d;
  logic [ColW-1:0]      sw_col_q, sw_col_d;
  logic [RowW-1:0]      sw_last_q, sw_last_d;
  tccw_pkg::state_e     sw_ret_q, sw_ret_d;
  logic [CellW-1:0]     cell_q, cell_d;

  logic [3:0]           fg_q, bg_q;
  logic                 raw_q, cur_en_q;

  logic                 out_valid_q, out_valid_d;
  logic [ColW-1:0]      out_col_q, out_col_d;
  logic [RowW-1:0]      out_row_q, out_row_d;
  logic [31:0]          out_scroll_q, out_scroll_d;
  logic [CellW-1:0]     out_cell_q, out_cell_d;
  logic                 out_vis_q, out_vis_d;

  logic                 mem_we;
  logic [CellW-1:0]     mem_wdata;
  logic [AddrW-1:0]     mem_waddr, mem_raddr;
  logic [CellW-1:0]     mem_rdata;
  logic                 in_acc;

  tccw_pkg::op_e        op;
  tccw_pkg::put_e       put_kind;
  logic                 tgt_ok, glyph_wrap, at_bottom, adv_scroll, tab_last;
  logic                 sweep_end, exec_long, fin, do_scroll, out_free, out_load;
  logic [RowW-1:0]      wr_row;
  logic [ColW-1:0]      wr_col;
  logic [OffW-1:0]      off_calc;

  // Cell store
  tccw_ram #(
    .Width (CellW),
    .Depth (tccw_pkg::DEPTH)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_acc),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_ready_o = (state_q == tccw_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // Start the cell read as the request is taken
  assign mem_raddr = tccw_pkg::cell_addr(
                       tccw_pkg::row_phys(in_req_i.target_row[RowW-1:0], top_q),
                       in_req_i.target_col[ColW-1:0]);

  // Decode the held request
  assign op     = tccw_pkg::op_e'(req_q.opcode);
  assign tgt_ok = (req_q.target_col < 8'(tccw_pkg::COLS)) &&
                  (req_q.target_row < 8'(tccw_pkg::ROWS));

  always_comb begin
    put_kind = tccw_pkg::PK_GLYPH;
    if (!raw_q) begin
      case (req_q.char_code)
        tccw_pkg::CH_TAB: put_kind = tccw_pkg::PK_TAB;
        tccw_pkg::CH_CR:  put_kind = tccw_pkg::PK_CR;
        tccw_pkg::CH_LF:  put_kind = tccw_pkg::PK_LF;
        tccw_pkg::CH_BS:  put_kind = tccw_pkg::PK_BS;
        default:          put_kind = tccw_pkg::PK_GLYPH;
      endcase
    end
  end

  // Cursor advance and sequencing conditions
  assign glyph_wrap = (cur_col_q == ColW'(tccw_pkg::COLS - 1));
  assign at_bottom  = (cur_row_q == RowW'(tccw_pkg::ROWS - 1));
  assign adv_scroll = glyph_wrap && at_bottom;
  assign tab_last   = (tab_cnt_q == TcW'(1));
  assign sweep_end  = (sw_col_q == ColW'(tccw_pkg::COLS - 1)) && (sw_row_q == sw_last_q);
  assign out_free   = !out_valid_q || out_ready_i;

  assign exec_long = ((op == tccw_pkg::OP_PUT) &&
                      ((put_kind == tccw_pkg::PK_TAB) ||
                       ((put_kind == tccw_pkg::PK_GLYPH) && adv_scroll) ||
                       ((put_kind == tccw_pkg::PK_LF) && at_bottom))) ||
                     (op inside {tccw_pkg::OP_CLS, tccw_pkg::OP_CLR_EOL,
                                 tccw_pkg::OP_CLR_EOS});

  assign fin = ((state_q == tccw_pkg::ST_EXEC) && !exec_long) ||
               ((state_q == tccw_pkg::ST_TAB) && tab_last && !adv_scroll);

  assign do_scroll = ((state_q == tccw_pkg::ST_EXEC) && (op == tccw_pkg::OP_PUT) &&
                      (((put_kind == tccw_pkg::PK_GLYPH) && adv_scroll) ||
                       ((put_kind == tccw_pkg::PK_LF) && at_bottom))) ||
                     ((state_q == tccw_pkg::ST_TAB) && adv_scroll);

  assign out_load = (fin || (state_q == tccw_pkg::ST_DONE)) && out_free;

  // Write address: sweep position or cursor
  assign wr_row    = (state_q == tccw_pkg::ST_SWEEP) ? sw_row_q : cur_row_q;
  assign wr_col    = (state_q == tccw_pkg::ST_SWEEP) ? sw_col_q : cur_col_q;
  assign mem_waddr = tccw_pkg::cell_addr(tccw_pkg::row_phys(wr_row, top_q), wr_col);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tccw_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = tccw_pkg::ST_EXEC;
        end
      end
      tccw_pkg::ST_EXEC: begin
        if (fin) begin
          state_d = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DONE;
        end else if ((op == tccw_pkg::OP_PUT) && (put_kind == tccw_pkg::PK_TAB)) begin
          state_d = tccw_pkg::ST_TAB;
        end else begin
          state_d = tccw_pkg::ST_SWEEP;
        end
      end
      tccw_pkg::ST_TAB: begin
        if (fin) begin
          state_d = out_free ? tccw_pkg::ST_IDLE : tccw_pkg::ST_DONE;
        end else if (adv_scroll) begin
          state_d = tccw_pkg::ST_SWEEP;
        end
      end
      tccw_pkg::ST_SWEEP: begin
        if (sweep_end) begin
          state_d = sw_ret_q;
        end
      end
      tccw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      default: state_d = tccw_pkg::ST_IDLE;
    endcase
  end

  // Datapath: cursor, sweeps, cell writes and result register
  always_comb begin
    req_d     = req_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    top_d     = top_q;
    scroll_d  = scroll_q;
    tab_cnt_d = tab_cnt_q;
    sw_row_d  = sw_row_q;
    sw_col_d  = sw_col_q;
    sw_last_d = sw_last_q;
    sw_ret_d  = sw_ret_q;
    cell_d    = cell_q;
    mem_we    = 1'b0;
    mem_wdata = tccw_pkg::BLANK_CELL;

    case (state_q)
      tccw_pkg::ST_IDLE: begin
        if (in_acc) begin
          req_d = in_req_i;
        end
      end
      tccw_pkg::ST_EXEC: begin
        cell_d = '0;
        case (op)
          tccw_pkg::OP_PUT: begin
            case (put_kind)
              tccw_pkg::PK_GLYPH: begin
                mem_we    = 1'b1;
                mem_wdata = {bg_q, fg_q, req_q.char_code};
                cur_col_d = glyph_wrap ? '0 : cur_col_q + ColW'(1);
                if (glyph_wrap && !at_bottom) begin
                  cur_row_d = cur_row_q + RowW'(1);
                end
              end
              tccw_pkg::PK_TAB: begin
                tab_cnt_d = TcW'(tccw_pkg::TAB_WIDTH) -
                            TcW'(cur_col_q % tccw_pkg::TAB_WIDTH);
              end
              tccw_pkg::PK_CR: begin
                cur_col_d = '0;
              end
              tccw_pkg::PK_LF: begin
                if (!at_bottom) begin
                  cur_row_d = cur_row_q + RowW'(1);
                end
              end
              tccw_pkg::PK_BS: begin
                if (cur_col_q != '0) begin
                  cur_col_d = cur_col_q - ColW'(1);
                end else if (cur_row_q != '0) begin
                  cur_row_d = cur_row_q - RowW'(1);
                  cur_col_d = ColW'(tccw_pkg::COLS - 1);
                end
              end
              default: ;
            endcase
          end
          tccw_pkg::OP_GOTO: begin
            if (tgt_ok) begin
              cur_col_d = req_q.target_col[ColW-1:0];
              cur_row_d = req_q.target_row[RowW-1:0];
            end
          end
          tccw_pkg::OP_CLS: begin
            cur_col_d = '0;
            cur_row_d = '0;
            sw_row_d  = '0;
            sw_col_d  = '0;
            sw_last_d = RowW'(tccw_pkg::ROWS - 1);
            sw_ret_d  = tccw_pkg::ST_DONE;
          end
          tccw_pkg::OP_CLR_EOL: begin
            sw_row_d  = cur_row_q;
            sw_col_d  = cur_col_q;
            sw_last_d = cur_row_q;
            sw_ret_d  = tccw_pkg::ST_DONE;
          end
          tccw_pkg::OP_CLR_EOS: begin
            sw_row_d  = cur_row_q;
            sw_col_d  = cur_col_q;
            sw_last_d = RowW'(tccw_pkg::ROWS - 1);
            sw_ret_d  = tccw_pkg::ST_DONE;
          end
          tccw_pkg::OP_READ: begin
            cell_d = tgt_ok ? mem_rdata : '0;
          end
          default: ;
        endcase
      end
      tccw_pkg::ST_TAB: begin
        // Write one space and advance
        mem_we    = 1'b1;
        mem_wdata = {bg_q, fg_q, tccw_pkg::CH_SPACE};
        cur_col_d = glyph_wrap ? '0 : cur_col_q + ColW'(1);
        if (glyph_wrap && !at_bottom) begin
          cur_row_d = cur_row_q + RowW'(1);
        end
        tab_cnt_d = tab_cnt_q - TcW'(1);
      end
      tccw_pkg::ST_SWEEP: begin
        // Blank one cell and step along the rows
        mem_we    = 1'b1;
        mem_wdata = tccw_pkg::BLANK_CELL;
        if (sw_col_q == ColW'(tccw_pkg::COLS - 1)) begin
          sw_col_d = '0;
          sw_row_d = sw_row_q + RowW'(1);
        end else begin
          sw_col_d = sw_col_q + ColW'(1);
        end
      end
      default: ;
    endcase

    // Scroll: rotate the top row and blank the new bottom row
    if (do_scroll) begin
      top_d     = (top_q == RowW'(tccw_pkg::ROWS - 1)) ? '0 : top_q + RowW'(1);
      scroll_d  = scroll_q + 32'd1;
      sw_row_d  = RowW'(tccw_pkg::ROWS - 1);
      sw_col_d  = '0;
      sw_last_d = RowW'(tccw_pkg::ROWS - 1);
      sw_ret_d  = ((state_q == tccw_pkg::ST_TAB) && !tab_last) ? tccw_pkg::ST_TAB
                                                               : tccw_pkg::ST_DONE;
    end
  end

  // Result register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_scroll_d = out_scroll_q;
    out_cell_d   = out_cell_q;
    out_vis_d    = out_vis_q;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_col_d    = cur_col_d;
      out_row_d    = cur_row_d;
      out_scroll_d = scroll_d;
      out_cell_d   = cell_d;
      out_vis_d    = cur_en_q;
    end else if (out_ready_i) begin
      out_valid_d  = 1'b0;
    end
  end

  // Hardware cursor position below the header row
  assign off_calc = OffW'(out_row_q) * OffW'(tccw_pkg::COLS) + OffW'(tccw_pkg::COLS) +
                    OffW'(out_col_q);

  assign out_valid_o                = out_valid_q;
  assign out_res_o.cursor_col       = tccw_pkg::out_col_t'(out_col_q);
  assign out_res_o.cursor_row       = tccw_pkg::out_row_t'(out_row_q);
  assign out_res_o.scroll_total     = out_scroll_q;
  assign out_res_o.cell_value       = out_cell_q;
  assign out_res_o.cursor_offset    = out_vis_q ? tccw_pkg::out_off_t'(off_calc) : '0;
  assign out_res_o.cursor_visible   = out_vis_q;

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::ST_SWEEP;
      cur_row_q   <= '0;
      cur_col_q   <= '0;
      top_q       <= '0;
      scroll_q    <= '0;
      tab_cnt_q   <= '0;
      sw_row_q    <= '0;
      sw_col_q    <= '0;
      sw_last_q   <= RowW'(tccw_pkg::ROWS - 1);
      sw_ret_q    <= tccw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_row_q   <= cur_row_d;
      cur_col_q   <= cur_col_d;
      top_q       <= top_d;
      scroll_q    <= scroll_d;
      tab_cnt_q   <= tab_cnt_d;
      sw_row_q    <= sw_row_d;
      sw_col_q    <= sw_col_d;
      sw_last_q   <= sw_last_d;
      sw_ret_q    <= sw_ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q     <= 4'd7;
      bg_q     <= 4'd0;
      raw_q    <= 1'b0;
      cur_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (tccw_pkg::cfg_idx_e'(cfg_idx_i))
        tccw_pkg::CFG_FG:     fg_q     <= cfg_data_i[3:0];
        tccw_pkg::CFG_BG:     bg_q     <= cfg_data_i[3:0];
        tccw_pkg::CFG_RAW:    raw_q    <= cfg_data_i[0];
        tccw_pkg::CFG_CURSOR: cur_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    cell_q       <= cell_d;
    out_col_q    <= out_col_d;
    out_row_q    <= out_row_d;
    out_scroll_q <= out_scroll_d;
    out_cell_q   <= out_cell_d;
    out_vis_q    <= out_vis_d;
  end

  // Scroll count only ever steps by one
  a_scroll_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (scroll_q == $past(scroll_q)) || (scroll_q == $past(scroll_q) + 32'd1))
    else $error("scroll count jumped");

  // The top row moves only together with a scroll
  a_top_moves_on_scroll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q != $past(top_q)) |-> (scroll_q == $past(scroll_q) + 32'd1))
    else $error("top row moved without a scroll");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_col_q < ColW'(tccw_pkg::COLS)) && (cur_row_q < RowW'(tccw_pkg::ROWS)))
    else $error("cursor off screen");

  // Cell writes only from the working states
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == tccw_pkg::ST_EXEC) || (state_q == tccw_pkg::ST_TAB) ||
               (state_q == tccw_pkg::ST_SWEEP))
    else $error("cell write outside a working state");

endmodule

`default_nettype wire

// File: src/tccw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tccw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1920
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
